// File: hdl/eqbm_pkg.sv
// Shared types and constants for the E/Q bus cycle master.
// Used by the front stage, the item queue, the back end and the top level.
`timescale 1ns / 1ps

package eqbm_pkg;

  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 48;
  localparam int unsigned TmoW      = 16;
  localparam int unsigned QDepth    = 2;

  localparam logic [15:0]     IdleAddr   = 16'hFFFF;
  localparam logic [TmoW-1:0] TmoDefault = 16'd512;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_TICK  = 1'b1
  } req_kind_e;

  typedef struct packed {
    req_kind_e   kind;
    logic [15:0] bus_address;
    logic        late_sample;
    logic        is_write;
    logic [7:0]  write_data;
    logic        e_level;
    logic        q_level;
    logic [7:0]  data_in;
  } item_t;

  // Packed so that the first field lands in the highest bits.
  typedef struct packed {
    logic [7:0]  read_data;
    logic [2:0]  failed_phase;
    logic        error_flag;
    logic        done_res;
    logic [7:0]  data_out;
    logic        data_drive;
    logic        rw_level;
    logic        ba_level;
    logic [15:0] addr_out;
    logic        addr_drive;
    logic        clock_pulse;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

endpackage

// File: hdl/e_q_bus_cycle_master.sv
// E/Q bus cycle master top level: front stage, item queue and back-end sequencer.
// A word passes the front register, a queue entry, then the back-end result register.
// Throughput: one word per cycle while results are taken; one state update per item.
// The two-entry queue lets the input side keep running while the result side stalls.
// Reset: idle, timeout 512, address undriven at 0xFFFF, BA and RW high, data undriven.
// Depends on eqbm_pkg, eqbm_front, eqbm_queue and eqbm_back.
`timescale 1ns / 1ps

module e_q_bus_cycle_master (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [eqbm_pkg::TmoW-1:0]       cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // bus_address, late_sample, is_write, write_data, e_level, q_level, data_in, zero pad
  input  logic [eqbm_pkg::InTdataW-1:0]   s_axis_tdata,
  // req_type
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // clock_pulse, addr_drive, addr_out, ba_level, rw_level, data_drive, data_out,
  // done_res, error_flag, failed_phase, read_data, zero pad
  output logic [eqbm_pkg::OutTdataW-1:0]  m_axis_tdata
);

  logic              push_valid, push_ready, pop_valid, pop_ready;
  eqbm_pkg::item_t   push_item, pop_item;
  eqbm_pkg::result_t res;

  assign cfg_ready_o = 1'b1;

  eqbm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_item_o   (push_item)
  );

  eqbm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  eqbm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {(eqbm_pkg::OutTdataW - eqbm_pkg::ResultW)'(0), res};

  // An error always ends the access.
  a_err_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.error_flag) |-> res.done_res)
    else $error("error without done");

  // The failing phase is reported only with an error and never beyond the last phase.
  a_fphase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((res.error_flag || res.failed_phase == 3'd0)
                       && res.failed_phase <= 3'd4))
    else $error("bad failed phase");

  // Read data only comes with a clean finish and without a clock pulse.
  a_rdata : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.read_data != 8'd0) |->
      (res.done_res && !res.error_flag && !res.clock_pulse))
    else $error("read data on wrong word");

  // The data bus value reads zero whenever it is not driven.
  a_ddrv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !res.data_drive) |-> res.data_out == 8'd0)
    else $error("undriven data nonzero");

endmodule

// File: hdl/eqbm_front.sv
// Front stage: takes input words, decodes kind and fields into one item.
// Depends on eqbm_pkg.
`timescale 1ns / 1ps

module eqbm_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [eqbm_pkg::InTdataW-1:0]   s_axis_tdata,
  input  logic                            s_axis_tuser,
  output logic                            push_valid_o,
  input  logic                            push_ready_i,
  output eqbm_pkg::item_t                 push_item_o
);

  logic            vld_q, vld_d;
  eqbm_pkg::item_t item_q, item_d;
  logic            take;

  assign s_axis_tready = !vld_q || push_ready_i;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_d             = item_q;
    vld_d              = vld_q;
    if (push_ready_i) begin
      vld_d = 1'b0;
    end
    if (take) begin
      vld_d              = 1'b1;
      item_d.kind        = s_axis_tuser ? eqbm_pkg::REQ_TICK : eqbm_pkg::REQ_START;
      item_d.bus_address = s_axis_tdata[15:0];
      item_d.late_sample = s_axis_tdata[16];
      item_d.is_write    = s_axis_tdata[17];
      item_d.write_data  = s_axis_tdata[25:18];
      item_d.e_level     = s_axis_tdata[26];
      item_d.q_level     = s_axis_tdata[27];
      item_d.data_in     = s_axis_tdata[35:28];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign push_valid_o = vld_q;
  assign push_item_o  = item_q;

endmodule

// File: hdl/eqbm_queue.sv
// Two-entry item queue between the front stage and the back end.
// Depends on eqbm_pkg.
`timescale 1ns / 1ps

module eqbm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  eqbm_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output eqbm_pkg::item_t pop_item_o
);

  localparam int unsigned PtrW = $clog2(eqbm_pkg::QDepth);
  localparam int unsigned CntW = $clog2(eqbm_pkg::QDepth + 1);

  eqbm_pkg::item_t mem_q [eqbm_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = cnt_q != CntW'(eqbm_pkg::QDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(eqbm_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(eqbm_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// File: hdl/eqbm_back.sv
// Back end: runs the E/Q phase sequencer on queued items and registers one result each.
// Holds the timeout register. Depends on eqbm_pkg.
`timescale 1ns / 1ps

module eqbm_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [eqbm_pkg::TmoW-1:0]   cfg_data_i,
  input  logic                        pop_valid_i,
  output logic                        pop_ready_o,
  input  eqbm_pkg::item_t             pop_item_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output eqbm_pkg::result_t           res_o
);

  typedef enum logic [2:0] {
    PH_ADDR  = 3'd0,
    PH_QRISE = 3'd1,
    PH_ERISE = 3'd2,
    PH_QFALL = 3'd3,
    PH_EFALL = 3'd4,
    PH_IDLE  = 3'd7
  } phase_e;

  phase_e                    phase_q, phase_d;
  logic [eqbm_pkg::TmoW-1:0] limit_q;
  logic [15:0]               wait_q, wait_d, wait_inc;
  logic [15:0]               haddr_q, haddr_d;
  logic                      hwrite_q, hwrite_d, hlate_q, hlate_d;
  logic [7:0]                hwdata_q, hwdata_d;
  logic [7:0]                prev_q, prev_d, last_q, last_d;
  logic                      adrv_q, adrv_d, ba_q, ba_d, rw_q, rw_d, ddrv_q, ddrv_d;
  logic [15:0]               baddr_q, baddr_d;
  logic [7:0]                bdata_q, bdata_d;
  logic                      out_vld_q;
  eqbm_pkg::result_t         out_q, res_d;
  logic                      pop, met, other_ok, tmo;

  assign pop_ready_o = !out_vld_q || res_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;
  assign wait_inc    = wait_q + 16'd1;
  assign tmo         = (wait_inc == '0) || (wait_inc >= limit_q);

  always_comb begin
    case (phase_q)
      PH_ADDR: begin
        met      = !pop_item_i.e_level && !pop_item_i.q_level;
        other_ok = 1'b1;
      end
      PH_QRISE: begin
        met      = pop_item_i.q_level;
        other_ok = !pop_item_i.e_level;
      end
      PH_ERISE: begin
        met      = pop_item_i.e_level;
        other_ok = pop_item_i.q_level;
      end
      PH_QFALL: begin
        met      = !pop_item_i.q_level;
        other_ok = pop_item_i.e_level;
      end
      default: begin
        met      = !pop_item_i.e_level;
        other_ok = !pop_item_i.q_level;
      end
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    wait_d   = wait_q;
    haddr_d  = haddr_q;
    hwrite_d = hwrite_q;
    hlate_d  = hlate_q;
    hwdata_d = hwdata_q;
    prev_d   = prev_q;
    last_d   = last_q;
    adrv_d   = adrv_q;
    ba_d     = ba_q;
    rw_d     = rw_q;
    ddrv_d   = ddrv_q;
    baddr_d  = baddr_q;
    bdata_d  = bdata_q;
    res_d    = '0;
    if (pop) begin
      if (pop_item_i.kind == eqbm_pkg::REQ_START) begin
        if (phase_q == PH_IDLE) begin
          haddr_d  = pop_item_i.bus_address;
          hlate_d  = pop_item_i.late_sample;
          hwrite_d = pop_item_i.is_write;
          hwdata_d = pop_item_i.write_data;
          prev_d   = '0;
          last_d   = '0;
          wait_d   = '0;
          phase_d  = PH_ADDR;
        end
      end else if (phase_q != PH_IDLE) begin
        if (met) begin
          if (!other_ok) begin
            res_d.done_res     = 1'b1;
            res_d.error_flag   = 1'b1;
            res_d.failed_phase = phase_q;
            phase_d            = PH_IDLE;
          end else if (phase_q == PH_ADDR) begin
            adrv_d  = 1'b1;
            baddr_d = haddr_q;
            ba_d    = 1'b0;
            if (hwrite_q) begin
              rw_d    = 1'b0;
              ddrv_d  = 1'b1;
              bdata_d = hwdata_q;
            end
            phase_d = PH_QRISE;
            wait_d  = '0;
          end else if (phase_q != PH_EFALL) begin
            phase_d = phase_e'(phase_q + 3'd1);
            wait_d  = '0;
          end else begin
            if (!hwrite_q) begin
              res_d.read_data = hlate_q ? prev_q : last_q;
            end
            ba_d    = 1'b1;
            baddr_d = eqbm_pkg::IdleAddr;
            if (hwrite_q) begin
              ddrv_d = 1'b0;
              rw_d   = 1'b1;
            end
            res_d.done_res = 1'b1;
            phase_d        = PH_IDLE;
          end
        end else begin
          if (phase_q == PH_EFALL && !hwrite_q) begin
            prev_d = last_q;
            last_d = pop_item_i.data_in;
          end
          res_d.clock_pulse = 1'b1;
          wait_d            = wait_inc;
          if (tmo) begin
            res_d.done_res     = 1'b1;
            res_d.error_flag   = 1'b1;
            res_d.failed_phase = phase_q;
            phase_d            = PH_IDLE;
          end
        end
      end
    end
    res_d.addr_drive = adrv_d;
    res_d.addr_out   = baddr_d;
    res_d.ba_level   = ba_d;
    res_d.rw_level   = rw_d;
    res_d.data_drive = ddrv_d;
    res_d.data_out   = ddrv_d ? bdata_d : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= eqbm_pkg::TmoDefault;
      phase_q   <= PH_IDLE;
      wait_q    <= '0;
      haddr_q   <= eqbm_pkg::IdleAddr;
      hwrite_q  <= 1'b0;
      hlate_q   <= 1'b0;
      hwdata_q  <= '0;
      prev_q    <= '0;
      last_q    <= '0;
      adrv_q    <= 1'b0;
      ba_q      <= 1'b1;
      rw_q      <= 1'b1;
      ddrv_q    <= 1'b0;
      baddr_q   <= eqbm_pkg::IdleAddr;
      bdata_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      phase_q  <= phase_d;
      wait_q   <= wait_d;
      haddr_q  <= haddr_d;
      hwrite_q <= hwrite_d;
      hlate_q  <= hlate_d;
      hwdata_q <= hwdata_d;
      prev_q   <= prev_d;
      last_q   <= last_d;
      adrv_q   <= adrv_d;
      ba_q     <= ba_d;
      rw_q     <= rw_d;
      ddrv_q   <= ddrv_d;
      baddr_q  <= baddr_d;
      bdata_q  <= bdata_d;
      if (pop) begin
        out_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= res_d;
    end
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

endmodule
